// File: sv/vasu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// View angle snap unit package
// Shared widths, angle constants, opcodes, status type and the small
// comparison helpers used by the update and snap logic.
// ----------------------------------------------------------------------------
package vasu_pkg;

    localparam int VAL_W = 18;
    localparam int AZ_W  = 17;
    localparam int EL_W  = 16;
    localparam int LIM_W = 15;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 80;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 15'd910;

    localparam logic OP_SET   = 1'b0;
    localparam logic OP_DELTA = 1'b1;

    // Working width for every angle sum and difference in the block.
    typedef logic signed [18:0] wide_t;

    localparam wide_t ANG_PI      = 19'sd32768;
    localparam wide_t ANG_HALF_PI = 19'sd16384;
    localparam wide_t ANG_TWO_PI  = 19'sd65536;
    localparam wide_t ANG_ZERO    = 19'sd0;

    // Axis classes; the snap logic tests X, Y and Z in that order.
    typedef enum logic [1:0] {
        AXIS_NONE = 2'd0,
        AXIS_X    = 2'd1,
        AXIS_Y    = 2'd2,
        AXIS_Z    = 2'd3
    } axis_t;

    typedef struct packed {
        axis_t      snap_axis;
        logic [5:0] look_flags;
        logic       near_zero;
    } snap_stat_t;

    // True when |x - c| is strictly below the limit.
    function automatic logic near_fn(wide_t x, wide_t c, logic [LIM_W-1:0] lim);
        wide_t       d;
        logic [18:0] m;
        d = x - c;
        m = d[18] ? 19'(-d) : d;
        return m < {4'b0000, lim};
    endfunction

    function automatic wide_t clamp_fn(wide_t x, wide_t lim);
        wide_t r;
        if (x > lim)
        begin
            r = lim;
        end
        else if (x < -lim)
        begin
            r = -lim;
        end
        else
        begin
            r = x;
        end
        return r;
    endfunction

endpackage

// File: sv/vasu_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// View angle update
// Forms the new stored azimuth and elevation from an absolute set or from
// deltas added to the stored angles, with the single azimuth wrap and clamps.
// ----------------------------------------------------------------------------
module vasu_update (
    input  logic                                opcode,
    input  logic signed [vasu_pkg::VAL_W-1:0]   azimuth_value,
    input  logic signed [vasu_pkg::VAL_W-1:0]   elevation_value,
    input  logic signed [vasu_pkg::AZ_W-1:0]    azimuth_state,
    input  logic signed [vasu_pkg::EL_W-1:0]    elevation_state,
    output logic signed [vasu_pkg::AZ_W-1:0]    azimuth_new,
    output logic signed [vasu_pkg::EL_W-1:0]    elevation_new
);

    vasu_pkg::wide_t az_sum;
    vasu_pkg::wide_t az_pick;
    vasu_pkg::wide_t el_pick;
    vasu_pkg::wide_t az_lim;
    vasu_pkg::wide_t el_lim;

    always_comb
    begin
        az_sum = vasu_pkg::wide_t'(azimuth_state) + vasu_pkg::wide_t'(azimuth_value);
        if (az_sum > vasu_pkg::ANG_PI)
        begin
            az_sum = az_sum - vasu_pkg::ANG_TWO_PI;
        end
        else if (az_sum < -vasu_pkg::ANG_PI)
        begin
            az_sum = az_sum + vasu_pkg::ANG_TWO_PI;
        end

        if (opcode == vasu_pkg::OP_DELTA)
        begin
            az_pick = az_sum;
            el_pick = vasu_pkg::wide_t'(elevation_state) +
                      vasu_pkg::wide_t'(elevation_value);
        end
        else
        begin
            az_pick = vasu_pkg::wide_t'(azimuth_value);
            el_pick = vasu_pkg::wide_t'(elevation_value);
        end

        az_lim = vasu_pkg::clamp_fn(az_pick, vasu_pkg::ANG_PI);
        el_lim = vasu_pkg::clamp_fn(el_pick, vasu_pkg::ANG_HALF_PI);
    end

    assign azimuth_new   = az_lim[vasu_pkg::AZ_W-1:0];
    assign elevation_new = el_lim[vasu_pkg::EL_W-1:0];

endmodule

// File: sv/vasu_snap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// View angle snap classifier
// Snaps each angle to a multiple of pi/2 that it is close to when both are close
// to one, taking the first match in priority order, and derives the axis class,
// looking-direction flags and zero flag.
module vasu_snap (
    input  logic signed [vasu_pkg::AZ_W-1:0]    azimuth,
    input  logic signed [vasu_pkg::EL_W-1:0]    elevation,
    input  logic        [vasu_pkg::LIM_W-1:0]   snap_limit,
    output logic signed [vasu_pkg::AZ_W-1:0]    snapped_azimuth,
    output logic signed [vasu_pkg::EL_W-1:0]    snapped_elevation,
    output vasu_pkg::snap_stat_t                stat
);

    vasu_pkg::wide_t az;
    vasu_pkg::wide_t el;
    vasu_pkg::wide_t aaz;
    vasu_pkg::wide_t ael;
    vasu_pkg::wide_t saz;
    vasu_pkg::wide_t sel;

    logic az_z, az_ph, az_pp, az_mh, az_mp;
    logic el_z, el_ph, el_mh;
    logic abs_az_h, abs_az_p, abs_el_h, az_any;
    logic saz_small, sel_small;

    always_comb
    begin
        az  = vasu_pkg::wide_t'(azimuth);
        el  = vasu_pkg::wide_t'(elevation);
        aaz = az[18] ? -az : az;
        ael = el[18] ? -el : el;

        az_z  = vasu_pkg::near_fn(az, vasu_pkg::ANG_ZERO, snap_limit);
        az_ph = vasu_pkg::near_fn(az, vasu_pkg::ANG_HALF_PI, snap_limit);
        az_pp = vasu_pkg::near_fn(az, vasu_pkg::ANG_PI, snap_limit);
        az_mh = vasu_pkg::near_fn(az, -vasu_pkg::ANG_HALF_PI, snap_limit);
        az_mp = vasu_pkg::near_fn(az, -vasu_pkg::ANG_PI, snap_limit);
        el_z  = vasu_pkg::near_fn(el, vasu_pkg::ANG_ZERO, snap_limit);
        el_ph = vasu_pkg::near_fn(el, vasu_pkg::ANG_HALF_PI, snap_limit);
        el_mh = vasu_pkg::near_fn(el, -vasu_pkg::ANG_HALF_PI, snap_limit);

        abs_az_h = vasu_pkg::near_fn(aaz, vasu_pkg::ANG_HALF_PI, snap_limit);
        abs_az_p = vasu_pkg::near_fn(aaz, vasu_pkg::ANG_PI, snap_limit);
        abs_el_h = vasu_pkg::near_fn(ael, vasu_pkg::ANG_HALF_PI, snap_limit);
        az_any   = az_z || abs_az_h || abs_az_p;

        // Snapping happens only when both angles sit near a pi/2 multiple;
        // the first matching target in priority order wins.
        saz = az;
        sel = el;
        if ((el_z || el_ph || el_mh) && (az_z || az_ph || az_pp || az_mh || az_mp))
        begin
            if (az_z)
            begin
                saz = vasu_pkg::ANG_ZERO;
            end
            else if (az_ph)
            begin
                saz = vasu_pkg::ANG_HALF_PI;
            end
            else if (az_pp)
            begin
                saz = vasu_pkg::ANG_PI;
            end
            else if (az_mh)
            begin
                saz = -vasu_pkg::ANG_HALF_PI;
            end
            else
            begin
                saz = -vasu_pkg::ANG_PI;
            end

            if (el_z)
            begin
                sel = vasu_pkg::ANG_ZERO;
            end
            else if (el_ph)
            begin
                sel = vasu_pkg::ANG_HALF_PI;
            end
            else
            begin
                sel = -vasu_pkg::ANG_HALF_PI;
            end
        end

        if (abs_az_h && el_z)
        begin
            stat.snap_axis = vasu_pkg::AXIS_X;
        end
        else if ((az_z || abs_az_p) && el_z)
        begin
            stat.snap_axis = vasu_pkg::AXIS_Y;
        end
        else if (abs_el_h)
        begin
            stat.snap_axis = vasu_pkg::AXIS_Z;
        end
        else
        begin
            stat.snap_axis = vasu_pkg::AXIS_NONE;
        end

        stat.look_flags[0] = !az[18] && az_ph && el_z;
        stat.look_flags[1] = (az[18] || (az == vasu_pkg::ANG_ZERO)) && az_mh && el_z;
        stat.look_flags[2] = el_z && az_z;
        stat.look_flags[3] = abs_az_p && el_z;
        stat.look_flags[4] = el_mh && az_any;
        stat.look_flags[5] = el_ph && az_any;

        saz_small      = vasu_pkg::near_fn(saz, vasu_pkg::ANG_ZERO, snap_limit);
        sel_small      = vasu_pkg::near_fn(sel, vasu_pkg::ANG_ZERO, snap_limit);
        stat.near_zero = saz_small && sel_small;
    end

    assign snapped_azimuth   = saz[vasu_pkg::AZ_W-1:0];
    assign snapped_elevation = sel[vasu_pkg::EL_W-1:0];

endmodule

// File: sv/view_angle_snap_unit_core.sv
`timescale 1ns / 1ps
// Pipeline: each item passes through one input register and then one result
// register before it is presented on the master side.
// Throughput: one transfer per cycle while the master side does not stall; the
// stored-angle update is combinational.
// Reset: the stored angles clear to zero, snap_limit returns to 910
// (five degrees) and both pipeline stages empty.
// ----------------------------------------------------------------------------
// View angle snap unit core
// Camera azimuth and elevation kept as binary angles (pi is 32768), with
// absolute or delta updates and snapping to multiples of pi/2.
// ----------------------------------------------------------------------------
module view_angle_snap_unit_core (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [17:0] azimuth_value, [35:18] elevation_value, [39:36] zero
    input  logic [vasu_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // [0] opcode
    input  logic                                 s_axis_tuser,

    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [16:0] azimuth_now, [32:17] elevation_now, [49:33] snapped_azimuth,
    // [65:50] snapped_elevation, [67:66] snap_axis, [73:68] look_flags,
    // [74] near_zero, [79:75] zero
    output logic [vasu_pkg::OUT_DATA_W-1:0]      m_axis_tdata,

    input  logic                                 snap_limit_we,
    input  logic [vasu_pkg::LIM_W-1:0]           snap_limit_wdata
);

    // Input stage. It empties whenever the result stage can take its item,
    // so a new transfer is taken every cycle while results keep flowing.
    logic                                  in_vld_reg;
    logic                                  in_op_reg;
    logic signed [vasu_pkg::VAL_W-1:0]     in_az_reg;
    logic signed [vasu_pkg::VAL_W-1:0]     in_el_reg;

    // Result stage and the stored view angles.
    logic                                  out_vld_reg;
    logic [vasu_pkg::OUT_DATA_W-1:0]       out_data_reg;
    logic [vasu_pkg::OUT_DATA_W-1:0]       out_data_next;
    logic signed [vasu_pkg::AZ_W-1:0]      azimuth_reg;
    logic signed [vasu_pkg::EL_W-1:0]      elevation_reg;
    logic signed [vasu_pkg::AZ_W-1:0]      azimuth_next;
    logic signed [vasu_pkg::EL_W-1:0]      elevation_next;
    logic [vasu_pkg::LIM_W-1:0]            snap_limit_reg;

    logic signed [vasu_pkg::AZ_W-1:0]      snapped_az;
    logic signed [vasu_pkg::EL_W-1:0]      snapped_el;
    vasu_pkg::snap_stat_t                  stat;

    logic advance;
    logic take_in;

    // The result stage moves when it is empty or its result is being taken.
    assign advance       = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = !in_vld_reg || advance;
    assign take_in       = s_axis_tvalid && s_axis_tready;

    // The update reads the stored angles, which already hold the effect of
    // every item that has left this stage, so deltas chain
    // correctly between back-to-back transfers.
    vasu_update u_update (
        .opcode          (in_op_reg),
        .azimuth_value   (in_az_reg),
        .elevation_value (in_el_reg),
        .azimuth_state   (azimuth_reg),
        .elevation_state (elevation_reg),
        .azimuth_new     (azimuth_next),
        .elevation_new   (elevation_next)
    );

    vasu_snap u_snap (
        .azimuth           (azimuth_next),
        .elevation         (elevation_next),
        .snap_limit        (snap_limit_reg),
        .snapped_azimuth   (snapped_az),
        .snapped_elevation (snapped_el),
        .stat              (stat)
    );

    assign out_data_next = {5'b00000, stat.near_zero, stat.look_flags, stat.snap_axis,
                            snapped_el, snapped_az, elevation_next, azimuth_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            azimuth_reg    <= '0;
            elevation_reg  <= '0;
            snap_limit_reg <= vasu_pkg::LIMIT_RESET;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_vld_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_vld_reg <= in_vld_reg;
            end
            if (advance && in_vld_reg)
            begin
                azimuth_reg   <= azimuth_next;
                elevation_reg <= elevation_next;
            end
            if (snap_limit_we)
            begin
                snap_limit_reg <= snap_limit_wdata;
            end
        end
    end

    // Payload registers carry no reset; their valid bits qualify them.
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_op_reg <= s_axis_tuser;
            in_az_reg <= s_axis_tdata[vasu_pkg::VAL_W-1:0];
            in_el_reg <= s_axis_tdata[2*vasu_pkg::VAL_W-1:vasu_pkg::VAL_W];
        end
        if (advance && in_vld_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// View angle snap unit testbench
// Drives absolute and delta angle updates into the core, with random idle
// and stall cycles on both stream sides. A behavioural predictor in this
// file works out every result, and each result transfer is compared field
// by field. A short directed list covers the clamp and wrap limits, the
// snapping edges and the tolerance extremes. Random phases follow, each
// with its own tolerance setting.
// ----------------------------------------------------------------------------
module testbench;

    localparam int ANGLE_PI      = 32768;
    localparam int ANGLE_HALF_PI = 16384;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_COUNT   = 6;
    localparam int PHASE_ITEMS   = 67;
    localparam int ROW_COUNT     = 24;

    // Axis class codes; the block tests X, Y and Z in that order.
    typedef vasu_pkg::axis_t axis_code_t;

    // Looking-direction flag bits.
    localparam logic [5:0] LOOK_POS_X = 6'b000001;
    localparam logic [5:0] LOOK_NEG_X = 6'b000010;
    localparam logic [5:0] LOOK_POS_Y = 6'b000100;
    localparam logic [5:0] LOOK_NEG_Y = 6'b001000;
    localparam logic [5:0] LOOK_POS_Z = 6'b010000;
    localparam logic [5:0] LOOK_NEG_Z = 6'b100000;

    typedef struct packed {
        logic signed [16:0] azimuth_now;
        logic signed [15:0] elevation_now;
        logic signed [16:0] snapped_azimuth;
        logic signed [15:0] snapped_elevation;
        axis_code_t         snap_axis;
        logic [5:0]         look_flags;
        logic               near_zero;
    } view_result_t;

    // One line of the directed list. A row may first change the tolerance,
    // and may carry a hand-written expectation instead of the predicted one.
    typedef struct {
        bit           wr_limit;
        int           limit;
        logic         op;
        int           az;
        int           el;
        bit           typed;
        view_result_t want;
    } stim_row_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [vasu_pkg::IN_DATA_W-1:0]     s_axis_tdata = '0;
    logic                               s_axis_tuser = 1'b0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [vasu_pkg::OUT_DATA_W-1:0]    m_axis_tdata;
    logic                               snap_limit_we = 1'b0;
    logic [vasu_pkg::LIM_W-1:0]         snap_limit_wdata = '0;

    // Predictor state: the stored angles and the tolerance as the block
    // should hold them after every accepted transfer.
    int                       track_az = 0;
    int                       track_el = 0;
    int                       tolerance = int'(vasu_pkg::LIMIT_RESET);

    view_result_t             pending_views[$];
    int                       error_count = 0;
    int                       cycle_count = 0;

    // Idle pattern state for the two sides.
    int                       tx_run = 0;
    bit                       tx_steady = 1'b0;
    int                       rx_run = 0;
    bit                       rx_steady = 1'b0;

    stim_row_t                stim_rows [ROW_COUNT];

    view_angle_snap_unit_core i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tuser     (s_axis_tuser),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .snap_limit_we    (snap_limit_we),
        .snap_limit_wdata (snap_limit_wdata)
    );

    always #5 clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic int mag(int x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic int clip(int x, int lim);
        if (x > lim)
        begin
            return lim;
        end
        if (x < -lim)
        begin
            return -lim;
        end
        return x;
    endfunction

    // Strict closeness test against the current tolerance.
    function automatic bit close_to(int x, int c);
        return mag(x - c) < tolerance;
    endfunction

    // Applies one update to the tracked angles and returns what the block
    // should report for it.
    function automatic view_result_t predict_view(logic op, int av, int ev);
        view_result_t r;
        int           az;
        int           el;
        int           sum;
        int           saz;
        int           sel;
        int           aaz;
        int           ael;
        bit           el_snaps;
        bit           az_snaps;
        bit           el0;
        bit           az0;
        bit           azh;
        bit           azp;
        bit           azany;
        axis_code_t   axis;
        logic [5:0]   flags;

        if (op == vasu_pkg::OP_SET)
        begin
            az = av;
            el = ev;
        end
        else
        begin
            // The azimuth wraps by one full turn at most, then saturates.
            sum = track_az + av;
            if (sum > ANGLE_PI)
            begin
                sum -= 2 * ANGLE_PI;
            end
            else if (sum < -ANGLE_PI)
            begin
                sum += 2 * ANGLE_PI;
            end
            az = sum;
            el = clip(track_el + ev, ANGLE_HALF_PI);
        end
        az = clip(az, ANGLE_PI);
        el = clip(el, ANGLE_HALF_PI);
        track_az = az;
        track_el = el;

        el_snaps = close_to(el, 0) || close_to(el, ANGLE_HALF_PI) ||
                   close_to(el, -ANGLE_HALF_PI);
        az_snaps = close_to(az, 0) || close_to(az, ANGLE_HALF_PI) ||
                   close_to(az, ANGLE_PI) || close_to(az, -ANGLE_HALF_PI) ||
                   close_to(az, -ANGLE_PI);

        // Both angles must be near a quarter turn before either snaps.
        saz = az;
        sel = el;
        if (el_snaps && az_snaps)
        begin
            if (close_to(az, 0))
                saz = 0;
            else if (close_to(az, ANGLE_HALF_PI))
                saz = ANGLE_HALF_PI;
            else if (close_to(az, ANGLE_PI))
                saz = ANGLE_PI;
            else if (close_to(az, -ANGLE_HALF_PI))
                saz = -ANGLE_HALF_PI;
            else if (close_to(az, -ANGLE_PI))
                saz = -ANGLE_PI;

            if (close_to(el, 0))
                sel = 0;
            else if (close_to(el, ANGLE_HALF_PI))
                sel = ANGLE_HALF_PI;
            else if (close_to(el, -ANGLE_HALF_PI))
                sel = -ANGLE_HALF_PI;
        end

        aaz   = mag(az);
        ael   = mag(el);
        el0   = ael < tolerance;
        az0   = aaz < tolerance;
        azh   = close_to(aaz, ANGLE_HALF_PI);
        azp   = close_to(aaz, ANGLE_PI);
        azany = az0 || azh || azp;

        if (azh && el0)
            axis = vasu_pkg::AXIS_X;
        else if ((az0 || azp) && el0)
            axis = vasu_pkg::AXIS_Y;
        else if (close_to(ael, ANGLE_HALF_PI))
            axis = vasu_pkg::AXIS_Z;
        else
            axis = vasu_pkg::AXIS_NONE;

        flags = '0;
        if (az >= 0 && close_to(az, ANGLE_HALF_PI) && el0)
            flags |= LOOK_POS_X;
        if (az <= 0 && close_to(az, -ANGLE_HALF_PI) && el0)
            flags |= LOOK_NEG_X;
        if (el0 && az0)
            flags |= LOOK_POS_Y;
        if (azp && el0)
            flags |= LOOK_NEG_Y;
        if (close_to(el, -ANGLE_HALF_PI) && azany)
            flags |= LOOK_POS_Z;
        if (close_to(el, ANGLE_HALF_PI) && azany)
            flags |= LOOK_NEG_Z;

        r.azimuth_now       = 17'(az);
        r.elevation_now     = 16'(el);
        r.snapped_azimuth   = 17'(saz);
        r.snapped_elevation = 16'(sel);
        r.snap_axis         = axis;
        r.look_flags        = flags;
        r.near_zero         = (mag(saz) < tolerance) && (mag(sel) < tolerance);
        return r;
    endfunction

    // Idle cycles before the next transfer on one side. Stretches of back
    // to back transfers are mixed at random with stretches of random gaps.
    function automatic int next_gap(ref int run_left, ref bit steady);
        if (run_left == 0)
        begin
            steady   = ($urandom_range(0, 2) == 0);
            run_left = $urandom_range(4, 30);
        end
        run_left--;
        return steady ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic bit field_differs(string label, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Offers one update on the slave side and, once the transfer has been
    // taken, records what the block should answer. The valid is left high;
    // a gap in the next call or the caller lowers it.
    task automatic send_update(logic op, int az, int el, bit typed, view_result_t want);
        int           gap;
        view_result_t predicted;

        gap = next_gap(tx_run, tx_steady);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, 18'(el), 18'(az)};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);

        predicted = predict_view(op, az, el);
        pending_views.push_back(typed ? want : predicted);
    endtask

    // Changes the tolerance once the block has drained.
    task automatic program_limit(int value);
        s_axis_tvalid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        snap_limit_we    <= 1'b1;
        snap_limit_wdata <= value[vasu_pkg::LIM_W-1:0];
        @(posedge clk);
        snap_limit_we    <= 1'b0;
        tolerance = value & 32'h7FFF;
    endtask

    // Result side: random stalls, then a field by field check of each
    // transfer against the oldest waiting expectation.
    initial
    begin : result_side
        int           stall;
        view_result_t got;
        view_result_t want;
        bit           bad;

        wait (rst_n === 1'b1);
        forever
        begin
            stall = next_gap(rx_run, rx_steady);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);

            got.azimuth_now       = m_axis_tdata[16:0];
            got.elevation_now     = m_axis_tdata[32:17];
            got.snapped_azimuth   = m_axis_tdata[49:33];
            got.snapped_elevation = m_axis_tdata[65:50];
            got.snap_axis         = axis_code_t'(m_axis_tdata[67:66]);
            got.look_flags        = m_axis_tdata[73:68];
            got.near_zero         = m_axis_tdata[74];

            if (pending_views.size() == 0)
            begin
                $display("%0t: result with nothing expected, data %h", $time,
                         m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = pending_views.pop_front();
                bad  = 1'b0;
                bad |= field_differs("azimuth_now", want.azimuth_now,
                                     got.azimuth_now);
                bad |= field_differs("elevation_now", want.elevation_now,
                                     got.elevation_now);
                bad |= field_differs("snapped_azimuth", want.snapped_azimuth,
                                     got.snapped_azimuth);
                bad |= field_differs("snapped_elevation", want.snapped_elevation,
                                     got.snapped_elevation);
                bad |= field_differs("snap_axis", want.snap_axis, got.snap_axis);
                bad |= field_differs("look_flags", want.look_flags,
                                     got.look_flags);
                bad |= field_differs("near_zero", want.near_zero, got.near_zero);
                if (bad)
                begin
                    error_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int    phase_limits [PHASE_COUNT];
        int    az_targets [5];
        int    el_targets [3];
        int    spread;
        int    kind;
        int    az;
        int    el;
        logic  op;

        az_targets = '{0, ANGLE_HALF_PI, ANGLE_PI, -ANGLE_HALF_PI, -ANGLE_PI};
        el_targets = '{0, ANGLE_HALF_PI, -ANGLE_HALF_PI};

        // Directed list. The first rows run at the reset tolerance of five
        // degrees; the last ones visit a zero tolerance, the largest value the
        // register takes and exactly a quarter turn.
        stim_rows = '{
            // Stored angles start at zero: both snap and the view looks along +Y.
            '{1'b0, 0, vasu_pkg::OP_SET, 0, 0, 1'b1,
              '{17'sd0, 16'sd0, 17'sd0, 16'sd0, vasu_pkg::AXIS_Y, LOOK_POS_Y, 1'b1}},
            // Absolute sets beyond the range clamp to +pi and +pi/2, or to -pi and -pi/2.
            '{1'b0, 0, vasu_pkg::OP_SET, 65536, 65536, 1'b1,
              '{17'sd32768, 16'sd16384, 17'sd32768, 16'sd16384, vasu_pkg::AXIS_Z,
                LOOK_NEG_Z, 1'b0}},
            '{1'b0, 0, vasu_pkg::OP_SET, -65536, -65536, 1'b1,
              '{-17'sd32768, -16'sd16384, -17'sd32768, -16'sd16384, vasu_pkg::AXIS_Z,
                LOOK_POS_Z, 1'b0}},
            // Full range of the input field.
            '{1'b0, 0, vasu_pkg::OP_SET, 131071, -131072, 1'b0, '0},
            '{1'b0, 0, vasu_pkg::OP_SET, -131072, 131071, 1'b0, '0},
            // Exact quarter and half turns on the horizon.
            '{1'b0, 0, vasu_pkg::OP_SET, 16384, 0, 1'b0, '0},
            '{1'b0, 0, vasu_pkg::OP_SET, -16384, 0, 1'b0, '0},
            '{1'b0, 0, vasu_pkg::OP_SET, 32768, 0, 1'b0, '0},
            '{1'b0, 0, vasu_pkg::OP_SET, -32768, 500, 1'b0, '0},
            // Just inside and just outside the tolerance.
            '{1'b0, 0, vasu_pkg::OP_SET, 17293, -909, 1'b0, '0},
            '{1'b0, 0, vasu_pkg::OP_SET, 17294, 0, 1'b0, '0},
            '{1'b0, 0, vasu_pkg::OP_SET, 16000, 16000, 1'b0, '0},
            // Azimuth far from any quarter turn, where nothing snaps, then near pi.
            '{1'b0, 0, vasu_pkg::OP_SET, 5000, 0, 1'b0, '0},
            '{1'b0, 0, vasu_pkg::OP_SET, 32000, 16384, 1'b0, '0},
            // Delta past +pi wraps round to negative azimuth.
            '{1'b0, 0, vasu_pkg::OP_DELTA, 2000, 0, 1'b0, '0},
            // Large deltas: the first saturates after its wrap, the second lands just below +pi; elevation clamps.
            '{1'b0, 0, vasu_pkg::OP_DELTA, -131072, -131072, 1'b0, '0},
            '{1'b0, 0, vasu_pkg::OP_DELTA, 131071, 131071, 1'b0, '0},
            '{1'b0, 0, vasu_pkg::OP_DELTA, 0, 0, 1'b0, '0},
            // A zero tolerance snaps nothing and raises no flag.
            '{1'b1, 0, vasu_pkg::OP_SET, 0, 0, 1'b1,
              '{17'sd0, 16'sd0, 17'sd0, 16'sd0, vasu_pkg::AXIS_NONE, 6'd0, 1'b0}},
            '{1'b0, 0, vasu_pkg::OP_SET, 16384, 16384, 1'b0, '0},
            // Tolerances of a quarter turn and beyond: several tests hold at once and
            // the priorities decide.
            '{1'b1, 32767, vasu_pkg::OP_SET, 5000, -3000, 1'b0, '0},
            '{1'b0, 0, vasu_pkg::OP_DELTA, 20000, 20000, 1'b0, '0},
            '{1'b1, 16384, vasu_pkg::OP_SET, 8192, 8192, 1'b0, '0},
            '{1'b0, 0, vasu_pkg::OP_SET, -24576, -8192, 1'b0, '0}
        };

        phase_limits = '{int'(vasu_pkg::LIMIT_RESET), 1, 16384, 32767,
                         $urandom_range(0, 32767), $urandom_range(100, 3000)};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].wr_limit)
            begin
                program_limit(stim_rows[i].limit);
            end
            send_update(stim_rows[i].op, stim_rows[i].az, stim_rows[i].el,
                        stim_rows[i].typed, stim_rows[i].want);
        end

        // Random phases. Most updates land close to a quarter turn so that
        // the snapping and flag logic is exercised; the rest are spread over
        // -65536 to 65536 or over every bit pattern of the input fields.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            program_limit(phase_limits[p]);
            spread = tolerance + tolerance / 2 + 2;
            if (spread > 40000)
            begin
                spread = 40000;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                kind = $urandom_range(0, 9);
                op   = logic'($urandom_range(0, 1));
                if (kind < 6)
                begin
                    az = az_targets[$urandom_range(0, 4)] +
                         int'($urandom_range(0, 2 * spread)) - spread;
                    el = el_targets[$urandom_range(0, 2)] +
                         int'($urandom_range(0, 2 * spread)) - spread;
                    // A delta is aimed from the current stored angles.
                    if (op == vasu_pkg::OP_DELTA)
                    begin
                        az -= track_az;
                        el -= track_el;
                    end
                end
                else if (kind < 8)
                begin
                    az = int'($urandom_range(0, 131072)) - 65536;
                    el = int'($urandom_range(0, 131072)) - 65536;
                end
                else
                begin
                    az = int'($urandom_range(0, 262143)) - 131072;
                    el = int'($urandom_range(0, 262143)) - 131072;
                end
                send_update(op, az, el, 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (error_count == 0)
        begin
            $display("testbench: done, clean");
        end
        else
        begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/vasu_pkg.sv
sv/vasu_update.sv
sv/vasu_snap.sv
sv/view_angle_snap_unit_core.sv
tb/testbench.sv
